// ===== design/eia_pkg.sv =====
`default_nettype none

package eia_pkg;

	localparam int ENTITY_COUNT_DEF = 256;
	localparam int COMPONENT_COUNT = 32;
	localparam int SYSTEM_COUNT = 4;

	localparam int ID_W = 8;
	localparam int MASK_W = 32;
	localparam int NUM_SYS = 4;
	localparam int CFG_IDX_W = 8;

	// masks are cut to the configured number of component bits
	localparam logic [MASK_W-1:0] COMP_KEEP = (COMPONENT_COUNT >= MASK_W) ? '1 :
		MASK_W'((64'd1 << COMPONENT_COUNT) - 64'd1);

	typedef enum logic [1:0] {
		KIND_CREATE  = 2'd0,
		KIND_DESTROY = 2'd1,
		KIND_SET     = 2'd2,
		KIND_GET     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_FREE   = 2'd1,
		ST_NO_ENTITY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_ADDR,
		CS_EXEC
	} ctrl_state_t;

	typedef struct packed {
		kind_t             kind;
		logic [ID_W-1:0]   entity_id;
		logic [MASK_W-1:0] new_mask;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    result_id;
		logic [MASK_W-1:0]  mask_now;
		status_t            status;
		logic [NUM_SYS-1:0] member_of;
		logic [NUM_SYS-1:0] entered;
		logic [NUM_SYS-1:0] left_systems;
	} out_item_t;

	typedef struct packed {
		logic load_item;
		logic resolve;
		logic execute;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

	typedef logic [NUM_SYS-1:0][MASK_W-1:0] sys_masks_t;

	function automatic logic [NUM_SYS-1:0] sys_hits(input logic [MASK_W-1:0] m,
		input sys_masks_t sm);
		logic [NUM_SYS-1:0] h;
		h = '0;
		for (int s = 0; s < NUM_SYS; s++) begin
			if (s < SYSTEM_COUNT && (m & sm[s]) != '0) begin
				h[s] = 1'b1;
			end
		end
		return h;
	endfunction

endpackage

`default_nettype wire

// ===== design/eia_ctrl.sv =====
`default_nettype none

module eia_ctrl import eia_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			CS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = CS_ADDR;
				end
			end
			CS_ADDR: begin
				cmd.resolve = 1'b1;
				state_d = CS_EXEC;
			end
			CS_EXEC: begin
				// hold until the result register can take the request
				if (stat.out_free) begin
					cmd.execute = 1'b1;
					state_d = CS_IDLE;
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/eia_dp.sv =====
`default_nettype none

module eia_dp import eia_pkg::*; #(
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire in_item_t             in_data,
	output out_item_t                 out_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MASK_W-1:0]    cfg_data,
	input  wire ctrl_cmd_t            cmd,
	output dp_stat_t                  stat
);

	localparam int IW = $clog2(ENTITY_COUNT);
	localparam int CW = $clog2(ENTITY_COUNT + 1);

	typedef struct packed {
		logic              exists;
		logic [MASK_W-1:0] mask;
	} row_t;

	sys_masks_t sys_mask_q;

	logic [CW-1:0] freed_count_q;
	logic [CW-1:0] fresh_next_q;
	logic [ENTITY_COUNT-1:0] valid_q;

	logic [ID_W-1:0] stack_mem [ENTITY_COUNT];
	row_t            tbl_mem [ENTITY_COUNT];

	in_item_t        item_q;
	logic [ID_W-1:0] stk_rd_q;
	logic [IW-1:0]   tgt_q;
	logic            got_q;
	logic            pop_q;
	logic            range_q;
	row_t            row_rd_q;
	logic            vld_rd_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic [CW-1:0]      cnt_m1;
	logic [IW+ID_W-1:0] id_ext;
	logic [IW+ID_W-1:0] stk_ext;
	logic [IW+ID_W-1:0] tgt_ext;
	logic [IW-1:0]      tgt_d;
	logic               got_d;
	logic               pop_d;
	logic               range_d;

	logic               old_ok;
	logic [MASK_W-1:0]  old_mask;
	logic [NUM_SYS-1:0] old_hits;
	logic [NUM_SYS-1:0] new_hits;
	out_item_t          res;
	logic               wr_en;
	row_t               wr_row;
	logic               push;
	logic               dec_freed;
	logic               inc_fresh;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign stat.out_free = !out_valid_q || !out_stall;

	assign cnt_m1 = freed_count_q - CW'(1);
	assign id_ext = {{IW{1'b0}}, item_q.entity_id};
	assign stk_ext = {{IW{1'b0}}, stk_rd_q};
	assign tgt_ext = {{ID_W{1'b0}}, tgt_q};

	// pick the table entry: top of the free list, next fresh id, or the named entity
	always_comb begin
		tgt_d = '0;
		got_d = 1'b0;
		pop_d = 1'b0;
		range_d = 1'b0;
		if (item_q.kind == KIND_CREATE) begin
			if (freed_count_q != '0) begin
				tgt_d = stk_ext[IW-1:0];
				got_d = 1'b1;
				pop_d = 1'b1;
			end else if (fresh_next_q < CW'(ENTITY_COUNT)) begin
				tgt_d = fresh_next_q[IW-1:0];
				got_d = 1'b1;
			end
		end else begin
			tgt_d = id_ext[IW-1:0];
			range_d = id_ext < (IW+ID_W)'(ENTITY_COUNT);
		end
	end

	assign old_ok = vld_rd_q && row_rd_q.exists;
	assign old_mask = vld_rd_q ? row_rd_q.mask : '0;
	assign old_hits = sys_hits(old_mask, sys_mask_q);
	assign new_hits = sys_hits(item_q.new_mask, sys_mask_q);

	always_comb begin
		res = '0;
		res.result_id = item_q.entity_id;
		res.status = ST_OK;
		wr_en = 1'b0;
		wr_row = '0;
		push = 1'b0;
		dec_freed = 1'b0;
		inc_fresh = 1'b0;
		if (item_q.kind == KIND_CREATE) begin
			if (got_q) begin
				res.result_id = tgt_ext[ID_W-1:0];
				res.mask_now = old_mask;
				res.member_of = old_hits;
				wr_en = 1'b1;
				wr_row.exists = 1'b1;
				wr_row.mask = old_mask;
				dec_freed = pop_q;
				inc_fresh = !pop_q;
			end else begin
				res.result_id = '0;
				res.status = ST_NO_FREE;
			end
		end else if (!range_q) begin
			res.status = ST_NO_ENTITY;
		end else begin
			case (item_q.kind)
				KIND_DESTROY: begin
					if (!old_ok) begin
						res.status = ST_NO_ENTITY;
						res.mask_now = old_mask;
						res.member_of = old_hits;
					end else begin
						res.left_systems = old_hits;
						wr_en = 1'b1;
						push = freed_count_q < CW'(ENTITY_COUNT);
					end
				end
				KIND_SET: begin
					res.mask_now = item_q.new_mask;
					res.member_of = new_hits;
					res.entered = new_hits & ~old_hits;
					res.left_systems = old_hits & ~new_hits;
					wr_en = 1'b1;
					wr_row.exists = old_ok;
					wr_row.mask = item_q.new_mask;
				end
				default: begin
					res.mask_now = old_mask;
					res.member_of = old_hits;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_mask_q <= '0;
			freed_count_q <= '0;
			fresh_next_q <= '0;
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_SYS)) begin
				sys_mask_q[cfg_index[$clog2(NUM_SYS)-1:0]] <= cfg_data;
			end
			if (cmd.execute) begin
				out_valid_q <= 1'b1;
				if (wr_en) begin
					valid_q[tgt_q] <= 1'b1;
				end
				if (dec_freed) begin
					freed_count_q <= cnt_m1;
				end
				if (push) begin
					freed_count_q <= freed_count_q + CW'(1);
				end
				if (inc_fresh) begin
					fresh_next_q <= fresh_next_q + CW'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= '{kind: in_data.kind, entity_id: in_data.entity_id,
				new_mask: in_data.new_mask & COMP_KEEP};
			stk_rd_q <= stack_mem[cnt_m1[IW-1:0]];
		end
		if (cmd.resolve) begin
			tgt_q <= tgt_d;
			got_q <= got_d;
			pop_q <= pop_d;
			range_q <= range_d;
			row_rd_q <= tbl_mem[tgt_d];
			vld_rd_q <= valid_q[tgt_d];
		end
		if (cmd.execute) begin
			out_q <= res;
			if (wr_en) begin
				tbl_mem[tgt_q] <= wr_row;
			end
			if (push) begin
				stack_mem[freed_count_q[IW-1:0]] <= item_q.entity_id;
			end
		end
	end

`ifndef ASSERT_OFF
	// every freed id was handed out earlier
	a_freed_le_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		freed_count_q <= fresh_next_q)
		else $error("free list holds more ids than were ever allocated");

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_next_q <= CW'(ENTITY_COUNT))
		else $error("fresh id counter ran past the entity count");

	a_exec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |-> stat.out_free)
		else $error("request finished while the result register was occupied");

	a_exec_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute |=> out_valid_q)
		else $error("finished request produced no result");
`endif

endmodule

`default_nettype wire

// ===== design/entity_id_allocator_with_masks.sv =====
// a request passes the load, resolve and execute steps; its result is registered on execute
// a new request is taken only once the previous one has finished, since the two dependent
// memory reads run in series (free-list top, then the mask table entry) before the update step
// a stalled output holds the request in the last step until the result register frees
// reset clears the counters, the valid bits, the system masks and the output valid at once;
// no clearing pass, requests are taken right after reset
`default_nettype none

module entity_id_allocator_with_masks import eia_pkg::*; #(
	parameter int ENTITY_COUNT = ENTITY_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MASK_W-1:0]    cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	eia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	eia_dp #(
		.ENTITY_COUNT (ENTITY_COUNT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

// ===== dv/entity_alloc_checker.sv =====
`timescale 1ns / 1ps

module entity_alloc_checker import eia_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire in_item_t             in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire out_item_t            out_data,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MASK_W-1:0]    cfg_data,
	output int                        mismatches,
	output int                        awaiting
);

	localparam int IDS = ENTITY_COUNT_DEF;

	logic [MASK_W-1:0] sys_req [NUM_SYS];
	logic [ID_W-1:0]   free_ids [IDS];
	int                free_depth;
	int                next_fresh;
	logic [MASK_W-1:0] comp_masks [IDS];
	logic              alive [IDS];
	out_item_t         pending_outcomes [$];

	function automatic logic [NUM_SYS-1:0] systems_touched(input logic [MASK_W-1:0] m);
		logic [NUM_SYS-1:0] hit;
		hit = '0;
		for (int s = 0; s < NUM_SYS && s < SYSTEM_COUNT; s++) begin
			hit[s] = |(m & sys_req[s]);
		end
		return hit;
	endfunction

	// applies one request to the tracked state and returns the result it must produce
	function automatic out_item_t entity_op_outcome(input in_item_t req);
		out_item_t          r;
		logic [NUM_SYS-1:0] was_in;
		logic [NUM_SYS-1:0] now_in;
		logic [MASK_W-1:0]  m;
		int                 id;
		r = '0;
		r.status = ST_OK;
		r.result_id = req.entity_id;
		id = req.entity_id;
		m = req.new_mask & COMP_KEEP;
		case (req.kind)
			KIND_CREATE: begin
				// most recently freed id first, then never-used ids in order
				if (free_depth > 0) begin
					free_depth--;
					id = free_ids[free_depth];
				end else if (next_fresh < IDS) begin
					id = next_fresh;
					next_fresh++;
				end else begin
					id = -1;
				end
				if (id < 0) begin
					r.result_id = '0;
					r.status = ST_NO_FREE;
				end else begin
					alive[id] = 1'b1;
					r.result_id = ID_W'(id);
					r.mask_now = comp_masks[id];
					r.member_of = systems_touched(comp_masks[id]);
				end
			end
			KIND_DESTROY: begin
				if (!alive[id]) begin
					r.status = ST_NO_ENTITY;
					r.mask_now = comp_masks[id];
					r.member_of = systems_touched(comp_masks[id]);
				end else begin
					r.left_systems = systems_touched(comp_masks[id]);
					comp_masks[id] = '0;
					alive[id] = 1'b0;
					free_ids[free_depth] = ID_W'(id);
					free_depth++;
				end
			end
			KIND_SET: begin
				was_in = systems_touched(comp_masks[id]);
				now_in = systems_touched(m);
				comp_masks[id] = m;
				r.mask_now = m;
				r.member_of = now_in;
				r.entered = now_in & ~was_in;
				r.left_systems = was_in & ~now_in;
			end
			default: begin
				r.mask_now = comp_masks[id];
				r.member_of = systems_touched(comp_masks[id]);
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int        bad;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SYS; i++) begin
				sys_req[i] = '0;
			end
			for (int i = 0; i < IDS; i++) begin
				free_ids[i] = '0;
				comp_masks[i] = '0;
				alive[i] = 1'b0;
			end
			free_depth = 0;
			next_fresh = 0;
			pending_outcomes.delete();
			mismatches <= 0;
			awaiting <= 0;
		end else begin
			bad = 0;
			if (cfg_valid && cfg_ready && cfg_index < NUM_SYS) begin
				sys_req[cfg_index] = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (pending_outcomes.size() == 0) begin
					$error("result with no request waiting: result_id %0d", out_data.result_id);
					bad++;
				end else begin
					want = pending_outcomes[0];
					pending_outcomes.delete(0);
					if (out_data.result_id !== want.result_id) begin
						$error("result_id: expected %0d, got %0d", want.result_id,
							out_data.result_id);
						bad++;
					end
					if (out_data.mask_now !== want.mask_now) begin
						$error("mask_now: expected %h, got %h", want.mask_now, out_data.mask_now);
						bad++;
					end
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, out_data.status);
						bad++;
					end
					if (out_data.member_of !== want.member_of) begin
						$error("member_of: expected %b, got %b", want.member_of,
							out_data.member_of);
						bad++;
					end
					if (out_data.entered !== want.entered) begin
						$error("entered: expected %b, got %b", want.entered, out_data.entered);
						bad++;
					end
					if (out_data.left_systems !== want.left_systems) begin
						$error("left_systems: expected %b, got %b", want.left_systems,
							out_data.left_systems);
						bad++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_outcomes.insert(pending_outcomes.size(), entity_op_outcome(in_data));
			end
			mismatches <= mismatches + bad;
			awaiting <= pending_outcomes.size();
		end
	end

endmodule

// ===== dv/entity_id_allocator_with_masks_test.sv =====
`timescale 1ns / 1ps

module entity_id_allocator_with_masks_test;
	import eia_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SYS_MASK_A = 0;
	localparam logic [CFG_IDX_W-1:0] REG_SYS_MASK_B = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SYS_MASK_C = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SYS_MASK_D = 3;

	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 250;
	localparam int QUIET_LIMIT = 2000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [MASK_W-1:0]    cfg_data = '0;
	int                   mismatches;
	int                   awaiting;

	// per phase mix of request kinds, in percent
	int create_pct [PHASES] = '{40, 85, 85, 15, 40, 70};
	int destroy_pct [PHASES] = '{30, 5, 5, 60, 25, 10};

	kind_t sent_kinds [$];
	logic  live_hint [ENTITY_COUNT_DEF] = '{default: 1'b0};
	int    requests_sent = 0;
	int    results_seen = 0;
	int    refused_creates = 0;
	int    mask_settings = 0;
	int    quiet_cycles = 0;

	always #1 clk = ~clk;

	entity_id_allocator_with_masks uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	entity_alloc_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	// keeps a rough list of live ids so destroys mostly hit, plus the watchdog
	always @(posedge clk) begin
		kind_t k;
		if (out_valid && !out_stall && sent_kinds.size() != 0) begin
			k = sent_kinds[0];
			sent_kinds.delete(0);
			results_seen++;
			if (out_data.status == ST_NO_FREE) begin
				refused_creates++;
			end
			if (k == KIND_CREATE && out_data.status == ST_OK) begin
				live_hint[out_data.result_id] = 1'b1;
			end
		end
		if (in_valid && !in_stall) begin
			sent_kinds.insert(sent_kinds.size(), in_data.kind);
			requests_sent++;
			if (in_data.kind == KIND_DESTROY) begin
				live_hint[in_data.entity_id] = 1'b0;
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// result side backpressure: short stalls, a few long ones, and calm stretches
	initial begin
		int pick;
		int len;
		@(posedge clk);
		forever begin
			pick = $urandom_range(0, 15);
			if (pick == 0) begin
				out_stall <= 1'b0;
				len = $urandom_range(50, 150);
			end else if (pick == 1) begin
				out_stall <= 1'b1;
				len = $urandom_range(10, 40);
			end else if (pick < 8) begin
				out_stall <= 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b0;
				len = $urandom_range(1, 4);
			end
			repeat (len) @(posedge clk);
		end
	end

	task automatic write_system_masks(input logic [MASK_W-1:0] ma, input logic [MASK_W-1:0] mb,
		input logic [MASK_W-1:0] mc, input logic [MASK_W-1:0] md);
		logic [MASK_W-1:0] vals [4];
		vals = '{ma, mb, mc, md};
		for (int r = REG_SYS_MASK_A; r <= REG_SYS_MASK_D; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= CFG_IDX_W'(r);
			cfg_data <= vals[r - REG_SYS_MASK_A];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		mask_settings++;
	endtask

	task automatic send(input kind_t k, input int id, input logic [MASK_W-1:0] m,
		input bit no_gaps);
		int pick;
		int len;
		pick = $urandom_range(0, 19);
		if (no_gaps || pick < 12) begin
			len = 0;
		end else if (pick < 19) begin
			len = $urandom_range(1, 3);
		end else begin
			len = $urandom_range(10, 40);
		end
		if (len > 0) begin
			in_valid <= 1'b0;
			repeat (len) @(posedge clk);
		end
		in_data <= '{kind: k, entity_id: ID_W'(id), new_mask: m};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// called right after an accepted request; holds off until all results are back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
	endtask

	function automatic int pick_target(input int pct_live);
		int start;
		int idx;
		start = $urandom_range(0, ENTITY_COUNT_DEF - 1);
		if ($urandom_range(0, 99) < pct_live) begin
			for (int i = 0; i < ENTITY_COUNT_DEF; i++) begin
				idx = (start + i) % ENTITY_COUNT_DEF;
				if (live_hint[idx]) begin
					return idx;
				end
			end
		end
		return start;
	endfunction

	function automatic logic [MASK_W-1:0] random_mask();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
			3: return $urandom & $urandom & $urandom;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int  roll;
		bit  calm;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disjoint low masks, top bit only, and everything
		write_system_masks(32'h0000_000F, 32'h0000_00F0, 32'h8000_0000, 32'hFFFF_FFFF);
		send(KIND_GET, 0, '0, 1'b0);
		send(KIND_DESTROY, 5, '0, 1'b0);
		send(KIND_SET, 7, '1, 1'b0);
		send(KIND_CREATE, 0, '0, 1'b0);
		send(KIND_CREATE, 0, '0, 1'b0);
		send(KIND_SET, 0, 32'h0000_0001, 1'b0);
		send(KIND_SET, 0, 32'h0000_0010, 1'b0);
		send(KIND_SET, 0, 32'h8000_0000, 1'b0);
		send(KIND_GET, 0, '1, 1'b0);
		send(KIND_DESTROY, 0, '0, 1'b0);
		send(KIND_DESTROY, 0, '0, 1'b0);
		send(KIND_SET, 1, '1, 1'b0);
		send(KIND_DESTROY, 1, '0, 1'b0);
		// reuses 1 then 0, then fresh ids up to 7, which still holds its mask
		repeat (8) send(KIND_CREATE, 255, '1, 1'b0);
		send(KIND_SET, 255, '0, 1'b0);
		send(KIND_GET, 255, '1, 1'b0);
		send(KIND_DESTROY, 255, '0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (4) @(posedge clk);
			case (p)
				0: write_system_masks('0, '0, '0, '0);
				1: write_system_masks('1, '1, '1, '1);
				2: write_system_masks(MASK_W'(1) << $urandom_range(0, 31),
					MASK_W'(1) << $urandom_range(0, 31), MASK_W'(1) << $urandom_range(0, 31),
					MASK_W'(1) << $urandom_range(0, 31));
				3: write_system_masks($urandom & $urandom, $urandom & $urandom,
					$urandom & $urandom, $urandom & $urandom);
				4: write_system_masks($urandom, $urandom, $urandom, $urandom);
				default: write_system_masks($urandom & $urandom & $urandom,
					$urandom & $urandom & $urandom, $urandom & $urandom & $urandom, '0);
			endcase
			calm = (p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					drain();
				end
				roll = $urandom_range(0, 99);
				if (roll < create_pct[p]) begin
					send(KIND_CREATE, $urandom_range(0, 255), random_mask(), calm);
				end else if (roll < create_pct[p] + destroy_pct[p]) begin
					send(KIND_DESTROY, pick_target(80), random_mask(), calm);
				end else if ($urandom_range(0, 2) != 0) begin
					send(KIND_SET, pick_target(70), random_mask(), calm);
				end else begin
					send(KIND_GET, pick_target(70), random_mask(), calm);
				end
			end
		end
		drain();
		repeat (8) @(posedge clk);

		$display("%0d requests sent, %0d results checked, %0d creates refused for lack of ids",
			requests_sent, results_seen, refused_creates);
		$display("%0d system mask settings applied, from all clear to all set", mask_settings);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
